// ----- design/pnlm_pkg.sv -----
// ----------------------------------------------------------------------------
// pnlm_pkg
// Shared constants and types for the pending notification LRU map.
// ----------------------------------------------------------------------------
package pnlm_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   localparam logic [2:0] CMD_WRITE       = 3'd0;
   localparam logic [2:0] CMD_ADD         = 3'd1;
   localparam logic [2:0] CMD_REMOVE_SLOT = 3'd2;
   localparam logic [2:0] CMD_REMOVE_NODE = 3'd3;
   localparam logic [2:0] CMD_REMOVE_FAB  = 3'd4;
   localparam logic [2:0] CMD_FIND_LRU    = 3'd5;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_NONE = 2'd2;

   localparam logic [1:0] KIND_UNICAST = 2'd1;

   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic walk_done;
   } dp_status_type;

endpackage

// ----- design/pnlm_ctrl.sv -----
// ----------------------------------------------------------------------------
// pnlm_ctrl
// Command sequencer: load, walk the pending list, then post the response.
// ----------------------------------------------------------------------------
module pnlm_ctrl import pnlm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type dp_status,
   output ctrl_cmd_type  ctrl_cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_WALK   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in        = state_ff;
      ctrl_cmd.load   = 1'b0;
      ctrl_cmd.step   = 1'b0;
      ctrl_cmd.finish = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctrl_cmd.load = 1'b1;
               state_in      = ST_WALK;
            end
         end
         ST_WALK: begin
            if (dp_status.walk_done) begin
               state_in = ST_FINISH;
            end else begin
               ctrl_cmd.step = 1'b1;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               ctrl_cmd.finish = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      priority if (ctrl_cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- design/pnlm_datapath.sv -----
// ----------------------------------------------------------------------------
// pnlm_datapath
// Pending list, binding table, in-order compaction and backward LRU scan.
// ----------------------------------------------------------------------------
module pnlm_datapath import pnlm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_cmd_type         ctrl_cmd,
   output dp_status_type        dp_status,
   input  logic [2:0]           req_cmd,
   input  logic [3:0]           req_slot,
   input  logic [1:0]           req_slot_kind,
   input  logic [7:0]           req_peer_fabric,
   input  logic [63:0]          req_peer_node,
   output logic [1:0]           rsp_status,
   output logic [7:0]           rsp_lru_fabric,
   output logic [63:0]          rsp_lru_node,
   output logic [4:0]           rsp_pending_count
);

   logic [2:0]           cmd_ff;
   logic [IDX_W-1:0]     slot_ff;
   logic [1:0]           kind_ff;
   logic [7:0]           fab_ff;
   logic [63:0]          node_ff;

   logic [IDX_W-1:0]     list_ff [TABLE_ENTRIES];
   logic [CNT_W-1:0]     total_ff;
   logic [1:0]           bkind_ff [TABLE_ENTRIES];
   logic [7:0]           bfab_ff  [TABLE_ENTRIES];
   logic [63:0]          bnode_ff [TABLE_ENTRIES];

   logic [CNT_W-1:0]     idx_ff, keep_ff;
   logic [TABLE_ENTRIES-1:0] seen_ff, peer_mask;
   logic                 found_ff;
   logic [IDX_W-1:0]     best_ff;

   logic [1:0]           status_ff;
   logic [7:0]           ofab_ff;
   logic [63:0]          onode_ff;
   logic [4:0]           count_ff;

   logic                 is_compact, is_find;
   logic [IDX_W-1:0]     pos, e, baddr;
   logic [1:0]           e_kind;
   logic [7:0]           e_fab;
   logic [63:0]          e_node;
   logic                 drop;
   logic [CNT_W-1:0]     idx_dec;
   logic                 list_full;

   assign is_compact = (cmd_ff == CMD_ADD) || (cmd_ff == CMD_REMOVE_SLOT) ||
                       (cmd_ff == CMD_REMOVE_NODE) || (cmd_ff == CMD_REMOVE_FAB);
   assign is_find    = (cmd_ff == CMD_FIND_LRU);
   assign idx_dec    = idx_ff - CNT_W'(1);
   assign pos        = is_find ? idx_dec[IDX_W-1:0] : idx_ff[IDX_W-1:0];
   assign e          = list_ff[pos];
   assign baddr      = ctrl_cmd.finish ? best_ff : e;
   assign e_kind     = bkind_ff[baddr];
   assign e_fab      = bfab_ff[baddr];
   assign e_node     = bnode_ff[baddr];
   assign list_full  = (keep_ff == CNT_W'(TABLE_ENTRIES));

   always_comb begin
      if (is_compact) begin
         dp_status.walk_done = (idx_ff == total_ff);
      end else if (is_find) begin
         dp_status.walk_done = (idx_ff == '0);
      end else begin
         dp_status.walk_done = 1'b1;
      end
   end

   always_comb begin
      unique case (cmd_ff)
         CMD_REMOVE_NODE: drop = (e_fab == fab_ff) && (e_node == node_ff);
         CMD_REMOVE_FAB:  drop = (e_fab == fab_ff);
         default:         drop = (e == slot_ff);
      endcase
   end

   // slots that are unicast bindings of the same peer as the current entry
   always_comb begin
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
         peer_mask[k] = (bkind_ff[k] == KIND_UNICAST) && (bfab_ff[k] == e_fab) &&
                        (bnode_ff[k] == e_node);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.load) begin
         cmd_ff  <= req_cmd;
         slot_ff <= req_slot;
         kind_ff <= req_slot_kind;
         fab_ff  <= req_peer_fabric;
         node_ff <= req_peer_node;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.load) begin
         idx_ff   <= (req_cmd == CMD_FIND_LRU) ? total_ff : '0;
         keep_ff  <= '0;
         seen_ff  <= '0;
         found_ff <= 1'b0;
      end else if (ctrl_cmd.step) begin
         if (is_find) begin
            idx_ff <= idx_dec;
            // walking backward: first unseen peer hit is its last position
            if (e_kind == KIND_UNICAST && !seen_ff[e]) begin
               found_ff <= 1'b1;
               best_ff  <= e;
               seen_ff  <= seen_ff | peer_mask;
            end
         end else begin
            idx_ff <= idx_ff + CNT_W'(1);
            if (!drop) begin
               list_ff[keep_ff[IDX_W-1:0]] <= e;
               keep_ff <= keep_ff + CNT_W'(1);
            end
         end
      end else if (ctrl_cmd.finish && cmd_ff == CMD_ADD && !list_full) begin
         list_ff[keep_ff[IDX_W-1:0]] <= slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         for (int k = 0; k < TABLE_ENTRIES; k++) begin
            bkind_ff[k] <= '0;
            bfab_ff[k]  <= '0;
            bnode_ff[k] <= '0;
         end
      end else if (ctrl_cmd.finish) begin
         if (cmd_ff == CMD_WRITE) begin
            bkind_ff[slot_ff] <= kind_ff;
            bfab_ff[slot_ff]  <= fab_ff;
            bnode_ff[slot_ff] <= node_ff;
         end
         if (cmd_ff == CMD_ADD && !list_full) begin
            total_ff <= keep_ff + CNT_W'(1);
         end else if (is_compact) begin
            total_ff <= keep_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.finish) begin
         if (cmd_ff == CMD_ADD && list_full) begin
            status_ff <= STATUS_FULL;
         end else if (is_find && !found_ff) begin
            status_ff <= STATUS_NONE;
         end else begin
            status_ff <= STATUS_OK;
         end
         if (is_find && found_ff) begin
            ofab_ff  <= e_fab;
            onode_ff <= e_node;
         end else begin
            ofab_ff  <= '0;
            onode_ff <= '0;
         end
         if (cmd_ff == CMD_ADD) begin
            if (list_full) begin
               count_ff <= 5'(keep_ff);
            end else begin
               count_ff <= 5'(keep_ff + CNT_W'(1));
            end
         end else if (is_compact) begin
            count_ff <= 5'(keep_ff);
         end else begin
            count_ff <= 5'(total_ff);
         end
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_lru_fabric    = ofab_ff;
   assign rsp_lru_node      = onode_ff;
   assign rsp_pending_count = count_ff;

endmodule

// ----- design/pending_notification_lru_map_unit.sv -----
// One transaction in flight. Add, remove and find walk the pending list, one
// entry per cycle; write and unknown commands skip the walk. The next command
// is accepted once the response is registered, and the response is held back
// while the previous one has not been taken. Synchronous active-high reset
// empties the list and clears every binding to unused.
// ----------------------------------------------------------------------------
// pending_notification_lru_map_unit
// Top level: pending slot list with binding table and LRU peer search.
// ----------------------------------------------------------------------------
module pending_notification_lru_map_unit import pnlm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_cmd,
   input  logic [3:0]  req_slot,
   input  logic [1:0]  req_slot_kind,
   input  logic [7:0]  req_peer_fabric,
   input  logic [63:0] req_peer_node,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_lru_fabric,
   output logic [63:0] rsp_lru_node,
   output logic [4:0]  rsp_pending_count
);

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   pnlm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_status (dp_status),
      .ctrl_cmd  (ctrl_cmd)
   );

   pnlm_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctrl_cmd          (ctrl_cmd),
      .dp_status         (dp_status),
      .req_cmd           (req_cmd),
      .req_slot          (req_slot),
      .req_slot_kind     (req_slot_kind),
      .req_peer_fabric   (req_peer_fabric),
      .req_peer_node     (req_peer_node),
      .rsp_status        (rsp_status),
      .rsp_lru_fabric    (rsp_lru_fabric),
      .rsp_lru_node      (rsp_lru_node),
      .rsp_pending_count (rsp_pending_count)
   );

endmodule

// ----- tb/tb_pending_notification_lru_map_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pending_notification_lru_map_unit
// Drives random and directed list/binding commands into the pending
// notification LRU map, predicts each response and checks it field by field.
// ----------------------------------------------------------------------------
module tb_pending_notification_lru_map_unit;
   import pnlm_pkg::*;

   typedef struct {
      logic [1:0]  status;
      logic [7:0]  fabric;
      logic [63:0] node;
      logic [4:0]  count;
   } rsp_type;

   class lru_map_scoreboard;
      logic [3:0]  queue_slot[16];
      int          queue_len;
      logic [1:0]  kind[16];
      logic [7:0]  fabric[16];
      logic [63:0] node[16];
      rsp_type     pending_rsp[$];
      int          mismatches;

      function void clear();
         queue_len = 0;
         mismatches = 0;
         for (int i = 0; i < 16; i++) begin
            kind[i] = 0;
            fabric[i] = 0;
            node[i] = 0;
            queue_slot[i] = 0;
         end
      endfunction

      // mode 0 by slot, 1 by fabric and node, 2 by fabric
      function void drop_entries(int mode, logic [3:0] s, logic [7:0] f, logic [63:0] n);
         int keep;
         logic [3:0] e;
         logic hit;
         keep = 0;
         for (int i = 0; i < queue_len; i++) begin
            e = queue_slot[i];
            if (mode == 0) hit = (e == s);
            else if (mode == 1) hit = (fabric[e] == f) && (node[e] == n);
            else hit = (fabric[e] == f);
            if (!hit) begin
               queue_slot[keep] = e;
               keep++;
            end
         end
         queue_len = keep;
      endfunction

      function void note_command(logic [2:0] c, logic [3:0] s, logic [1:0] k,
                                 logic [7:0] f, logic [63:0] n);
         rsp_type r;
         int rep[16];
         bit seen[16];
         int last_pos[16];
         int best, best_pos;
         bit found;
         logic [3:0] e;
         r.status = STATUS_OK;
         r.fabric = 0;
         r.node = 0;
         case (c)
            CMD_WRITE: begin
               kind[s] = k;
               fabric[s] = f;
               node[s] = n;
            end
            CMD_ADD: begin
               drop_entries(0, s, 0, 0);
               if (queue_len >= 16) r.status = STATUS_FULL;
               else begin
                  queue_slot[queue_len] = s;
                  queue_len++;
               end
            end
            CMD_REMOVE_SLOT: drop_entries(0, s, 0, 0);
            CMD_REMOVE_NODE: drop_entries(1, 0, f, n);
            CMD_REMOVE_FAB: drop_entries(2, 0, f, 0);
            CMD_FIND_LRU: begin
               for (int i = 0; i < 16; i++) begin
                  rep[i] = i;
                  seen[i] = 0;
                  last_pos[i] = 0;
                  if (kind[i] == KIND_UNICAST)
                     for (int j = 0; j < 16; j++)
                        if (kind[j] == KIND_UNICAST && fabric[j] == fabric[i] &&
                            node[j] == node[i]) begin
                           rep[i] = j;
                           break;
                        end
               end
               for (int i = 0; i < queue_len; i++) begin
                  e = queue_slot[i];
                  if (kind[e] == KIND_UNICAST) begin
                     seen[rep[e]] = 1;
                     last_pos[rep[e]] = i;
                  end
               end
               found = 0;
               best = 0;
               best_pos = 0;
               for (int i = 0; i < 16; i++)
                  if (seen[i] && (!found || last_pos[i] < best_pos)) begin
                     found = 1;
                     best = i;
                     best_pos = last_pos[i];
                  end
               if (found) begin
                  r.fabric = fabric[best];
                  r.node = node[best];
               end else r.status = STATUS_NONE;
            end
            default: ;
         endcase
         r.count = queue_len[4:0];
         pending_rsp.push_back(r);
      endfunction

      function void check_response(rsp_type a);
         rsp_type x;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response status=%0d", a.status);
            return;
         end
         x = pending_rsp.pop_front();
         if (a.status !== x.status || a.fabric !== x.fabric || a.node !== x.node ||
             a.count !== x.count) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: exp st=%0d fab=%0h node=%0h cnt=%0d,",
                         " got st=%0d fab=%0h node=%0h cnt=%0d"},
                        x.status, x.fabric, x.node, x.count,
                        a.status, a.fabric, a.node, a.count);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [2:0]  req_cmd = 0;
   logic [3:0]  req_slot = 0;
   logic [1:0]  req_slot_kind = 0;
   logic [7:0]  req_peer_fabric = 0;
   logic [63:0] req_peer_node = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_lru_fabric;
   logic [63:0] rsp_lru_node;
   logic [4:0]  rsp_pending_count;

   lru_map_scoreboard sb;
   bit stim_done = 0;
   bit hold_off = 0;

   pending_notification_lru_map_unit i_dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // small pools of fabric/node values so matches are common
   function automatic logic [7:0] pick_fabric();
      int p;
      p = $urandom_range(0, 9);
      if (p == 0) return 8'hff;
      if (p == 1) return 8'($urandom);
      return 8'($urandom_range(0, 2));
   endfunction

   function automatic logic [63:0] pick_node();
      int p;
      p = $urandom_range(0, 9);
      if (p == 0) return '1;
      if (p == 1) return {$urandom, $urandom};
      return {60'h8000_0000_0000_000, 4'($urandom_range(0, 2))};
   endfunction

   task automatic send(logic [2:0] c, logic [3:0] s, logic [1:0] k,
                       logic [7:0] f, logic [63:0] n);
      req_valid <= 1;
      req_cmd <= c;
      req_slot <= s;
      req_slot_kind <= k;
      req_peer_fabric <= f;
      req_peer_node <= n;
      do @(posedge clock); while (!req_ready);
      sb.note_command(c, s, k, f, n);
   endtask

   task automatic send_random();
      int p;
      logic [2:0] c;
      p = $urandom_range(0, 99);
      if (p < 20) c = CMD_WRITE;
      else if (p < 55) c = CMD_ADD;
      else if (p < 65) c = CMD_REMOVE_SLOT;
      else if (p < 72) c = CMD_REMOVE_NODE;
      else if (p < 77) c = CMD_REMOVE_FAB;
      else if (p < 96) c = CMD_FIND_LRU;
      else c = 3'($urandom_range(6, 7));
      send(c, 4'($urandom), ($urandom_range(0, 3) == 0) ? 2'($urandom) : 2'd1,
           pick_fabric(), pick_node());
   endtask

   task automatic pause(int n);
      req_valid <= 0;
      repeat (n) @(posedge clock);
   endtask

   initial begin
      int g;
      sb = new();
      sb.clear();
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: empty search, fill the list, re-adds that move a slot, removals
      send(CMD_FIND_LRU, 0, 0, 0, 0);
      send(CMD_WRITE, 0, 1, 8'hff, '1);
      send(CMD_WRITE, 15, 1, 8'hff, '1);
      send(CMD_WRITE, 3, 2, 8'h00, 64'h0);
      send(CMD_WRITE, 4, 3, 8'h01, 64'h5);
      send(CMD_WRITE, 5, 1, 8'h01, 64'h5);
      for (int i = 15; i >= 0; i--) send(CMD_ADD, 4'(i), 0, 0, 0);
      send(CMD_ADD, 7, 0, 0, 0);
      send(CMD_FIND_LRU, 0, 0, 0, 0);
      send(CMD_ADD, 15, 0, 0, 0);
      send(CMD_FIND_LRU, 0, 0, 0, 0);
      send(3'd6, 0, 0, 0, 0);
      send(3'd7, 15, 3, 8'hff, '1);
      send(CMD_REMOVE_NODE, 0, 0, 8'h01, 64'h5);
      send(CMD_REMOVE_FAB, 0, 0, 8'hff, 0);
      send(CMD_REMOVE_SLOT, 9, 0, 0, 0);
      send(CMD_FIND_LRU, 0, 0, 0, 0);
      for (int n = 0; n < 1500; n++) begin
         if (n == 300) hold_off = 1;
         send_random();
         g = pick_gap();
         if (n % 200 > 150) g = 0;
         if (g > 0) pause(g);
      end
      req_valid <= 0;
      stim_done = 1;
   end

   // receiver: random stalls plus one long hold-off
   initial begin
      bit long_done;
      long_done = 0;
      rsp_ready <= 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off && !long_done) begin
            long_done = 1;
            rsp_ready <= 0;
            repeat (300) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(0, 99) < 25) ? 1'b0 : 1'b1;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response('{rsp_status, rsp_lru_fabric, rsp_lru_node, rsp_pending_count});

   initial begin
      wait (stim_done);
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_rsp.size() == 0)
         $display("tb_pending_notification_lru_map_unit passed");
      else
         $display("tb_pending_notification_lru_map_unit failed");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("tb_pending_notification_lru_map_unit failed");
      $finish;
   end

endmodule
